// ----- rtl/pcrl_pkg.sv -----
`timescale 1ns / 1ps
package pcrl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [15:0] WINDOW_RESET = 16'd1000;
    localparam logic [15:0] MAX_RESET    = 16'd10;
    localparam logic [19:0] BLOCK_RESET  = 20'd10000;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_MAX    = 2'd1,
        CFG_BLOCK  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        REASON_NEW     = 3'd0,
        REASON_OK      = 3'd1,
        REASON_BLOCKED = 3'd2,
        REASON_RATE    = 3'd3,
        REASON_ZERO    = 3'd4,
        REASON_FULL    = 3'd5
    } reason_t;

    typedef struct packed {
        logic [31:0] client_ip;
        logic [47:0] now_ms;
    } item_t;

    typedef struct packed {
        logic    accepted;
        reason_t reason;
    } result_t;

    typedef struct packed {
        logic [15:0] window_ms;
        logic [15:0] max_attempts;
        logic [19:0] block_ms;
    } cfg_t;

    // word passed from front to back
    typedef struct packed {
        item_t item;
        logic  zero_ip;
    } word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- rtl/pcrl_front.sv -----
`timescale 1ns / 1ps
module pcrl_front import pcrl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  item_t                 item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  q_status_t             q_status,
    output logic                  busy,
    output logic                  push,
    output word_t                 push_word,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW: cfg_next.window_ms    = cfg_data[15:0];
                CFG_MAX:    cfg_next.max_attempts = cfg_data[15:0];
                CFG_BLOCK:  cfg_next.block_ms     = cfg_data[19:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ms    <= WINDOW_RESET;
            cfg_reg.max_attempts <= MAX_RESET;
            cfg_reg.block_ms     <= BLOCK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg               = cfg_reg;
    assign busy              = q_status.full;
    assign push              = start && !q_status.full;
    assign push_word.item    = item;
    // zero address is tagged here so the back end skips the scan
    assign push_word.zero_ip = (item.client_ip == 32'd0);

endmodule

// ----- rtl/pcrl_queue.sv -----
`timescale 1ns / 1ps
module pcrl_queue import pcrl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  word_t     push_word,
    input  logic      pop,
    output q_status_t q_status,
    output word_t     head
);

    localparam logic [1:0] DEPTH = 2'd2;

    word_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign q_status.full  = (count_reg == DEPTH);
    assign q_status.empty = (count_reg == 2'd0);
    assign head           = slot_reg[rd_ptr_reg];

endmodule

// ----- rtl/pcrl_back.sv -----
`timescale 1ns / 1ps
module pcrl_back import pcrl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  q_status_t q_status,
    input  word_t     q_head,
    output logic      pop,
    output logic      done,
    output result_t   result
);

    typedef struct packed {
        logic [31:0] address;
        logic [47:0] window_start;
        logic [15:0] count;
        logic [47:0] block_until;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_DECIDE
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    entry_t                   mem [TABLE_ENTRIES];
    entry_t                   rd_entry_reg;
    state_t                   state_reg;
    item_t                    cur_reg;
    entry_t                   ent_reg;
    logic [IDX_W-1:0]         issue_idx_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic                     rd_live_reg;
    logic                     free_found_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     blocked_reg;
    logic                     elapsed_reg;
    logic                     over_reg;
    logic [15:0]              cnt_inc_reg;
    logic [47:0]              until_reg;
    logic                     done_reg;
    result_t                  result_reg;

    logic             rd_hit;
    logic             rd_free;
    logic             scan_end;
    logic             free_any;
    logic [IDX_W-1:0] free_slot;
    logic [47:0]      diff;
    logic [48:0]      sum;
    logic [15:0]      cnt_inc;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    result_t          decide_result;

    // scan compare, one entry per cycle behind the registered read
    assign rd_hit    = rd_live_reg && valid_reg[rd_idx_reg]
                       && (rd_entry_reg.address == cur_reg.client_ip);
    assign rd_free   = rd_live_reg && !valid_reg[rd_idx_reg];
    assign scan_end  = rd_live_reg && !rd_hit && (rd_idx_reg == LAST_IDX);
    assign free_any  = free_found_reg || rd_free;
    assign free_slot = free_found_reg ? free_idx_reg : rd_idx_reg;
    assign pop       = (state_reg == S_IDLE) && !q_status.empty;

    // evaluate stage arithmetic
    assign diff    = cur_reg.now_ms - ent_reg.window_start;
    assign sum     = {1'b0, cur_reg.now_ms} + 49'(cfg.block_ms);
    assign cnt_inc = (ent_reg.count == COUNT_MAX) ? ent_reg.count : ent_reg.count + 16'd1;

    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = hit_idx_reg;
        mem_wdata     = ent_reg;
        decide_result = '{accepted: 1'b1, reason: REASON_OK};
        if (state_reg == S_SCAN && scan_end && free_any)
        begin
            mem_we                 = 1'b1;
            mem_waddr              = free_slot;
            mem_wdata.address      = cur_reg.client_ip;
            mem_wdata.window_start = cur_reg.now_ms;
            mem_wdata.count        = 16'd1;
            mem_wdata.block_until  = 48'd0;
        end
        else if (state_reg == S_DECIDE)
        begin
            mem_we          = 1'b1;
            mem_wdata.count = cnt_inc_reg;
            if (blocked_reg)
            begin
                decide_result = '{accepted: 1'b0, reason: REASON_BLOCKED};
            end
            else if (elapsed_reg)
            begin
                mem_wdata.window_start = cur_reg.now_ms;
                mem_wdata.count        = 16'd0;
                mem_wdata.block_until  = over_reg ? until_reg : 48'd0;
                if (over_reg)
                begin
                    decide_result = '{accepted: 1'b0, reason: REASON_RATE};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= mem[issue_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            ent_reg        <= '0;
            issue_idx_reg  <= '0;
            rd_idx_reg     <= '0;
            hit_idx_reg    <= '0;
            free_idx_reg   <= '0;
            rd_live_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            blocked_reg    <= 1'b0;
            elapsed_reg    <= 1'b0;
            over_reg       <= 1'b0;
            cnt_inc_reg    <= '0;
            until_reg      <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '{accepted: 1'b0, reason: REASON_NEW};
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        cur_reg <= q_head.item;
                        if (q_head.zero_ip)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{accepted: 1'b0, reason: REASON_ZERO};
                        end
                        else
                        begin
                            state_reg      <= S_SCAN;
                            issue_idx_reg  <= '0;
                            rd_live_reg    <= 1'b0;
                            free_found_reg <= 1'b0;
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_live_reg <= 1'b1;
                    rd_idx_reg  <= issue_idx_reg;
                    if (issue_idx_reg != LAST_IDX)
                    begin
                        issue_idx_reg <= issue_idx_reg + 1'b1;
                    end
                    if (rd_hit)
                    begin
                        ent_reg     <= rd_entry_reg;
                        hit_idx_reg <= rd_idx_reg;
                        state_reg   <= S_EVAL;
                    end
                    else if (scan_end)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                        if (free_any)
                        begin
                            valid_reg[free_slot] <= 1'b1;
                            result_reg <= '{accepted: 1'b1, reason: REASON_NEW};
                        end
                        else
                        begin
                            result_reg <= '{accepted: 1'b1, reason: REASON_FULL};
                        end
                    end
                    else if (rd_free && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= rd_idx_reg;
                    end
                end
                S_EVAL:
                begin
                    blocked_reg <= (ent_reg.block_until > cur_reg.now_ms);
                    elapsed_reg <= (diff > 48'(cfg.window_ms));
                    over_reg    <= (cnt_inc > cfg.max_attempts);
                    cnt_inc_reg <= cnt_inc;
                    until_reg   <= sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
                    state_reg   <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    done_reg   <= 1'b1;
                    result_reg <= decide_result;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/per_ip_connection_rate_limiter.sv -----
`timescale 1ns / 1ps
// Per-source connection rate limiter. Each word on item (client_ip, now_ms)
// is taken at a rising edge with start high and busy low, and gets exactly
// one result word on result, in order, shown for one cycle with done high;
// there is no way to hold results off, so take them when done is high. A
// two-word queue sits in front of the table engine, so start is taken while
// the engine works and busy only rises when both queue slots are filled.
// The engine scans its TABLE_ENTRIES-entry table one entry per cycle
// through a single registered memory read port: an unknown source (new
// entry or table full) is answered once the scan has read the last entry,
// a source found at an entry goes on through an evaluate and a decide
// state, and a zero address is answered in the cycle after dequeue, with
// no scan. The engine dequeues a word only from idle, so the scan sets the
// sustained rate while the queue stays filled. Results for zero addresses
// can come in consecutive cycles.
// Valid bits clear at reset; no clearing pass is needed. Configuration
// writes (cfg_we, cfg_index, cfg_data) take effect at the next edge and
// should be made only while no word is in flight; index 3 is ignored.
module per_ip_connection_rate_limiter import pcrl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    word_t     push_word;
    word_t     q_head;
    cfg_t      cfg;

    // front: config registers, accept, zero-address tag
    pcrl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .busy      (busy),
        .push      (push),
        .push_word (push_word),
        .cfg       (cfg)
    );

    // decoupling queue
    pcrl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .q_status  (q_status),
        .head      (q_head)
    );

    // back: table scan, window/block update, result
    pcrl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_status (q_status),
        .q_head   (q_head),
        .pop      (pop),
        .done     (done),
        .result   (result)
    );

    // words in flight: queue plus the one in the engine
    logic [1:0] outstanding_reg;
    logic [1:0] outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (push && !done)
        begin
            outstanding_next = outstanding_reg + 2'd1;
        end
        else if (done && !push)
        begin
            outstanding_next = outstanding_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 2'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (outstanding_reg != 2'd0))
        else $error("result with no word in flight");

    a_busy_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (outstanding_reg == 2'd3) |-> busy)
        else $error("word taken with queue and engine full");

    a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.accepted == ((result.reason == REASON_NEW)
                                   || (result.reason == REASON_OK)
                                   || (result.reason == REASON_FULL))))
        else $error("accepted flag disagrees with reason");

endmodule
